// ===== rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, field widths and codes for the sorted timer queue.
// Depends on nothing; every other file of the block imports it.
package stq_pkg;

  localparam int TIMERS_DEF = 16;
  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 31;
  localparam int ID_W       = 4;
  localparam int FUNC_W     = 2;
  localparam int KIND_W     = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PROC = 2'd2;

  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd2;

  localparam logic ST_OK          = 1'b0;
  localparam logic ST_NOT_PENDING = 1'b1;

  localparam logic [TIME_W-1:0] TIMEOUT_NONE = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay_ms;
    logic [TIME_W-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [ID_W-1:0]   expired_id;
    logic [TIME_W-1:0] next_timeout_ms;
    logic              last;
  } res_t;

  function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic status,
                                  logic [ID_W-1:0] id, logic [TIME_W-1:0] next,
                                  logic last);
    res_t r;
    r.kind            = kind;
    r.status          = status;
    r.expired_id      = id;
    r.next_timeout_ms = next;
    r.last            = last;
    return r;
  endfunction

endpackage

// ===== rtl/stq_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the sorted timer queue: valid/ready plus one command word.
// Depends on stq_pkg for field widths.
interface stq_in_if;
  import stq_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ID_W-1:0]    timer_id;
  logic [DELAY_W-1:0] delay_ms;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, func, timer_id, delay_ms, now_ms, input ready);
  modport sink   (input valid, func, timer_id, delay_ms, now_ms, output ready);
endinterface

// ===== rtl/stq_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the sorted timer queue: valid/ready plus one result word.
// Depends on stq_pkg for field widths.
interface stq_out_if;
  import stq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              status;
  logic [ID_W-1:0]   expired_id;
  logic [TIME_W-1:0] next_timeout_ms;
  logic              last;

  modport source (output valid, kind, status, expired_id, next_timeout_ms, last,
                  input ready);
  modport sink   (input valid, kind, status, expired_id, next_timeout_ms, last,
                  output ready);
endinterface

// ===== rtl/stq_time_cmp.sv =====
`timescale 1ns / 1ps
// Shared wrapping-time compare unit: difference a - b and "a later than b".
// Depends on stq_pkg for the time width.
module stq_time_cmp (
  input  logic [stq_pkg::TIME_W-1:0] a,
  input  logic [stq_pkg::TIME_W-1:0] b,
  output logic [stq_pkg::TIME_W-1:0] diff,
  output logic                       after
);
  import stq_pkg::*;

  assign diff  = a - b;
  assign after = (diff != '0) && !diff[TIME_W-1];
endmodule

// ===== rtl/stq_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the sorted timer queue: ordered queue memory, pending flags,
// insert/remove/expiry walks over the memory. Uses stq_pkg and stq_time_cmp.
module stq_seq #(
  parameter int TIMERS = stq_pkg::TIMERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  stq_pkg::item_t in_word,
  input  logic           out_free,
  output logic           emit,
  output stq_pkg::res_t  res
);
  import stq_pkg::*;

  localparam int IDX_W = $clog2(TIMERS);
  localparam int CNT_W = $clog2(TIMERS + 1);

  typedef struct packed {
    logic [IDX_W-1:0]  id;
    logic [TIME_W-1:0] dl;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REM_RD, S_REM_SCAN, S_INS_RD, S_INS_SCAN, S_SHF_RD, S_SHF_WR,
    S_INS_PUT, S_P_CHK, S_P_HEAD, S_EMIT
  } state_t;

  typedef enum logic [1:0] {RET_ADD, RET_DEL, RET_PROC} ret_t;

  state_t            state;
  ret_t              ret;
  logic [IDX_W-1:0]  id_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] dl_new;
  logic [CNT_W-1:0]  count;
  logic [TIMERS-1:0] pending;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  pos;
  logic              found;
  logic              emit_more;
  res_t              res_q;

  entry_t            q_mem [TIMERS];
  entry_t            rdata;
  entry_t            wdata;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic              we;

  logic [TIME_W-1:0] cmp_b;
  logic [TIME_W-1:0] cmp_diff;
  logic              cmp_after;

  logic [CNT_W-1:0]  ptr_inc;
  logic [CNT_W-1:0]  ptr_dec;
  logic [CNT_W-1:0]  count_m1;
  logic              ptr_last;
  logic [IDX_W-1:0]  tid;
  logic              tid_ok;
  logic              pend_hit;

  assign ptr_inc  = ptr + CNT_W'(1);
  assign ptr_dec  = ptr - CNT_W'(1);
  assign count_m1 = count - CNT_W'(1);
  assign ptr_last = (ptr == count_m1);
  assign tid      = IDX_W'(in_word.timer_id);
  assign tid_ok   = 32'(in_word.timer_id) < 32'(TIMERS);
  assign pend_hit = tid_ok && pending[tid];

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_EMIT) && out_free;
  assign res      = res_q;

  assign cmp_b = (state == S_P_HEAD) ? now_q : dl_new;

  stq_time_cmp u_cmp (
    .a     (rdata.dl),
    .b     (cmp_b),
    .diff  (cmp_diff),
    .after (cmp_after)
  );

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (state)
      S_REM_SCAN: begin
        if (ptr_inc < count) begin
          raddr = ptr_inc[IDX_W-1:0];
        end
        we    = found;
        waddr = ptr_dec[IDX_W-1:0];
      end
      S_INS_SCAN: begin
        if (ptr_inc < count) begin
          raddr = ptr_inc[IDX_W-1:0];
        end
      end
      S_SHF_RD: begin
        raddr = count_m1[IDX_W-1:0];
      end
      S_SHF_WR: begin
        if (ptr != pos) begin
          raddr = ptr_dec[IDX_W-1:0];
        end
        we    = 1'b1;
        waddr = ptr_inc[IDX_W-1:0];
      end
      S_INS_PUT: begin
        we       = 1'b1;
        waddr    = pos[IDX_W-1:0];
        wdata.id = id_q;
        wdata.dl = dl_new;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      q_mem[waddr] <= wdata;
    end
    rdata <= q_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= RET_ADD;
      count     <= '0;
      pending   <= '0;
      found     <= 1'b0;
      emit_more <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            id_q      <= tid;
            now_q     <= in_word.now_ms;
            dl_new    <= in_word.now_ms + {1'b0, in_word.delay_ms};
            emit_more <= 1'b0;
            case (in_word.func)
              FUNC_ADD: begin
                if (pend_hit) begin
                  ret   <= RET_ADD;
                  state <= S_REM_RD;
                end else if (tid_ok) begin
                  state <= S_INS_RD;
                end else begin
                  res_q <= mk_res(KIND_STATUS, ST_OK, '0, '0, 1'b1);
                  state <= S_EMIT;
                end
              end
              FUNC_DEL: begin
                if (pend_hit) begin
                  ret   <= RET_DEL;
                  state <= S_REM_RD;
                end else begin
                  res_q <= mk_res(KIND_STATUS, ST_NOT_PENDING, '0, '0, 1'b1);
                  state <= S_EMIT;
                end
              end
              FUNC_PROC: begin
                state <= S_P_CHK;
              end
              default: begin
                res_q <= mk_res(KIND_STATUS, ST_OK, '0, '0, 1'b1);
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_REM_RD: begin
          ptr   <= '0;
          found <= 1'b0;
          state <= S_REM_SCAN;
        end
        S_REM_SCAN: begin
          if (rdata.id == id_q) begin
            found <= 1'b1;
          end
          if (ptr_last) begin
            count         <= count_m1;
            pending[id_q] <= 1'b0;
            case (ret)
              RET_ADD: begin
                state <= S_INS_RD;
              end
              RET_PROC: begin
                res_q     <= mk_res(KIND_EXPIRED, ST_OK, ID_W'(id_q), '0, 1'b0);
                emit_more <= 1'b1;
                state     <= S_EMIT;
              end
              default: begin
                res_q <= mk_res(KIND_STATUS, ST_OK, '0, '0, 1'b1);
                state <= S_EMIT;
              end
            endcase
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_INS_RD: begin
          ptr <= '0;
          if (count == CNT_W'(TIMERS)) begin
            res_q <= mk_res(KIND_STATUS, ST_OK, '0, '0, 1'b1);
            state <= S_EMIT;
          end else if (count == '0) begin
            pos   <= '0;
            state <= S_INS_PUT;
          end else begin
            state <= S_INS_SCAN;
          end
        end
        S_INS_SCAN: begin
          if (cmp_after) begin
            pos   <= ptr;
            state <= S_SHF_RD;
          end else if (ptr_last) begin
            pos   <= count;
            state <= S_INS_PUT;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_SHF_RD: begin
          ptr   <= count_m1;
          state <= S_SHF_WR;
        end
        S_SHF_WR: begin
          if (ptr == pos) begin
            state <= S_INS_PUT;
          end else begin
            ptr <= ptr_dec;
          end
        end
        S_INS_PUT: begin
          count         <= count + CNT_W'(1);
          pending[id_q] <= 1'b1;
          res_q         <= mk_res(KIND_STATUS, ST_OK, '0, '0, 1'b1);
          state         <= S_EMIT;
        end
        S_P_CHK: begin
          if (count == '0) begin
            res_q     <= mk_res(KIND_NEXT, ST_OK, '0, TIMEOUT_NONE, 1'b1);
            emit_more <= 1'b0;
            state     <= S_EMIT;
          end else begin
            state <= S_P_HEAD;
          end
        end
        S_P_HEAD: begin
          if (cmp_after) begin
            res_q     <= mk_res(KIND_NEXT, ST_OK, '0, cmp_diff, 1'b1);
            emit_more <= 1'b0;
            state     <= S_EMIT;
          end else begin
            id_q  <= rdata.id;
            ret   <= RET_PROC;
            state <= S_REM_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= emit_more ? S_P_CHK : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// Sorted deadline timer queue: top level with the result output register.
// Depends on stq_pkg, stq_in_if, stq_out_if and stq_seq.
//
// Channels: item takes one command word (add/restart, delete, process) with
// the current wrapping millisecond time; result gives the words it causes,
// the final one of each command marked by last.
// One command is worked at a time; item.ready is high only while idle.
// Work per command, n timers queued (walks over the queue memory, which has
// one read port and one write port, go one entry a cycle):
//   unused code, ignored add, delete of an idle timer: a status word, no walk
//   delete of a pending timer: a remove walk over the queue
//   add: an insert scan, then a shift walk unless it goes at the tail;
//   restart: a remove walk, then the add
//   process: a remove walk for each expired head timer, each giving an expired
//   word, then a head check and the timeout report (TIMEOUT_NONE once empty).
// The next command can be taken once the last word of a command is in the output register.
// Reset empties the queue and clears all pending flags; no clearing pass.
// A stalled receiver holds the sequencer at its next result word.
module sorted_timer_queue #(
  parameter int TIMERS = stq_pkg::TIMERS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  stq_in_if.sink    item,
  stq_out_if.source result
);
  import stq_pkg::*;

  item_t item_word;
  res_t  res_word;
  res_t  out_word;
  logic  in_ready;
  logic  emit;
  logic  out_valid;
  logic  out_free;

  assign item_word = {item.func, item.timer_id, item.delay_ms, item.now_ms};
  assign item.ready = in_ready;
  assign out_free   = !out_valid || result.ready;

  stq_seq #(.TIMERS(TIMERS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .in_word  (item_word),
    .out_free (out_free),
    .emit     (emit),
    .res      (res_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= res_word;
    end
  end

  assign result.valid           = out_valid;
  assign result.kind            = out_word.kind;
  assign result.status          = out_word.status;
  assign result.expired_id      = out_word.expired_id;
  assign result.next_timeout_ms = out_word.next_timeout_ms;
  assign result.last            = out_word.last;
endmodule

// ===== bench/sorted_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_timer_queue: directed table, a full-queue fill, then random timer traffic.
// Depends on stq_pkg, stq_in_if, stq_out_if and the sorted_timer_queue RTL.
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_IDS = TIMERS_DEF;

  typedef struct {
    item_t w;
    bit    typed;
    res_t  res;
  } plan_row_t;

  logic clk;
  logic rst;

  stq_in_if  item ();
  stq_out_if result ();

  sorted_timer_queue dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  // timer model state
  logic [TIME_W-1:0] due_ms [NUM_IDS];
  bit                armed [NUM_IDS];
  logic [ID_W-1:0]   fire_order [$];

  res_t      awaited_words [$];
  plan_row_t plan [$];
  int        faults = 0;
  int        snd_idle = 0;
  int        rcv_stall = 0;
  int        hold_len = 0;

  function automatic bit later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d != '0 && !d[TIME_W-1];
  endfunction

  function automatic void disarm(logic [ID_W-1:0] id);
    for (int i = 0; i < fire_order.size(); i++) begin
      if (fire_order[i] == id) begin
        fire_order.delete(i);
        break;
      end
    end
    armed[id] = 1'b0;
  endfunction

  function automatic void advance_timer_queue(item_t w, bit typed, res_t fixed);
    res_t              outs [$];
    res_t              r;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] d;
    int                pos;
    r = '{kind: KIND_STATUS, status: ST_OK, expired_id: '0, next_timeout_ms: '0,
          last: 1'b1};
    case (w.func)
      FUNC_ADD: begin
        if (armed[w.timer_id]) disarm(w.timer_id);
        due_ms[w.timer_id] = w.now_ms + TIME_W'(w.delay_ms);
        pos = 0;
        while (pos < fire_order.size() &&
               !later_than(due_ms[fire_order[pos]], due_ms[w.timer_id]))
          pos++;
        fire_order.insert(pos, w.timer_id);
        armed[w.timer_id] = 1'b1;
        outs.push_back(r);
      end
      FUNC_DEL: begin
        if (armed[w.timer_id]) disarm(w.timer_id);
        else r.status = ST_NOT_PENDING;
        outs.push_back(r);
      end
      FUNC_PROC: begin
        while (fire_order.size() > 0 && !later_than(due_ms[fire_order[0]], w.now_ms)) begin
          id = fire_order[0];
          disarm(id);
          outs.push_back('{kind: KIND_EXPIRED, status: ST_OK, expired_id: id,
                           next_timeout_ms: '0, last: 1'b0});
        end
        r.kind = KIND_NEXT;
        if (fire_order.size() == 0) begin
          r.next_timeout_ms = TIMEOUT_NONE;
        end else begin
          d = due_ms[fire_order[0]] - w.now_ms;
          r.next_timeout_ms = d[TIME_W-1] ? '0 : d;
        end
        outs.push_back(r);
      end
      default: outs.push_back(r);
    endcase
    if (typed) awaited_words.push_back(fixed);
    else foreach (outs[i]) awaited_words.push_back(outs[i]);
  endfunction

  function automatic void plan_row(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                   logic [DELAY_W-1:0] dly, logic [TIME_W-1:0] now,
                                   bit typed = 1'b0, logic [KIND_W-1:0] k = KIND_STATUS,
                                   logic st = ST_OK, logic [TIME_W-1:0] nx = '0);
    plan_row_t p;
    p.w     = '{func: f, timer_id: id, delay_ms: dly, now_ms: now};
    p.typed = typed;
    p.res   = '{kind: k, status: st, expired_id: '0, next_timeout_ms: nx, last: 1'b1};
    plan.push_back(p);
  endfunction

  task automatic offer_word(item_t w, bit typed, res_t fixed);
    while ($urandom_range(99) < snd_idle) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid    <= 1'b1;
    item.func     <= w.func;
    item.timer_id <= w.timer_id;
    item.delay_ms <= w.delay_ms;
    item.now_ms   <= w.now_ms;
    do @(posedge clk); while (!item.ready);
    advance_timer_queue(w, typed, fixed);
  endtask

  task automatic drain_results();
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: check each word, stall at random or on a hold-off request
  initial begin
    res_t got;
    res_t want;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        got = '{kind: result.kind, status: result.status, expired_id: result.expired_id,
                next_timeout_ms: result.next_timeout_ms, last: result.last};
        if (awaited_words.size() == 0) begin
          $error("unexpected result word: kind %0d id %0d next %0h", got.kind,
                 got.expired_id, got.next_timeout_ms);
          faults++;
        end else begin
          want = awaited_words.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            faults++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            faults++;
          end
          if (got.expired_id !== want.expired_id) begin
            $error("expired_id: expected %0d, got %0d", want.expired_id, got.expired_id);
            faults++;
          end
          if (got.next_timeout_ms !== want.next_timeout_ms) begin
            $error("next_timeout_ms: expected %0h, got %0h", want.next_timeout_ms,
                   got.next_timeout_ms);
            faults++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            faults++;
          end
        end
      end
      if (hold_len > 0) begin
        result.ready <= 1'b0;
        hold_len     <= hold_len - 1;
      end else begin
        result.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  initial begin
    item_t             w;
    res_t              none;
    logic [TIME_W-1:0] wall_ms;
    int                pick;
    int                snd_plan [4];
    int                rcv_plan [4];
    snd_plan = '{0, 64, 0, 20};
    rcv_plan = '{0, 0, 64, 20};
    none = '0;
    rst            = 1'b1;
    item.valid     = 1'b0;
    item.func      = FUNC_ADD;
    item.timer_id  = '0;
    item.delay_ms  = '0;
    item.now_ms    = '0;

    plan_row(FUNC_PROC, 0, 0, 0, 1, KIND_NEXT, ST_OK, TIMEOUT_NONE);
    plan_row(FUNC_DEL, 5, 0, 0, 1, KIND_STATUS, ST_NOT_PENDING);
    plan_row(FUNC_UNUSED, 15, '1, '1, 1);
    plan_row(FUNC_ADD, 0, 0, 0, 1);
    plan_row(FUNC_PROC, 0, 0, 0);
    plan_row(FUNC_ADD, 15, '1, '1, 1);
    plan_row(FUNC_PROC, 0, 0, '1);
    plan_row(FUNC_ADD, 3, 100, 1000);
    plan_row(FUNC_ADD, 4, 100, 1000);
    plan_row(FUNC_ADD, 7, 50, 1000);
    plan_row(FUNC_ADD, 3, 10, 1020);
    plan_row(FUNC_DEL, 7, 0, 1030, 1);
    plan_row(FUNC_DEL, 7, 0, 1030, 1, KIND_STATUS, ST_NOT_PENDING);
    plan_row(FUNC_PROC, 0, 0, 1100);
    plan_row(FUNC_PROC, 0, 0, 32'hFFFF_FFF0);
    plan_row(FUNC_ADD, 9, 31'h20, 32'hFFFF_FFF0);
    plan_row(FUNC_ADD, 10, 0, 32'hFFFF_FFF0);
    plan_row(FUNC_PROC, 0, 0, 5);
    plan_row(FUNC_ADD, 12, '1, 5);
    plan_row(FUNC_DEL, 9, 0, 6, 1);
    plan_row(FUNC_PROC, 0, 0, 6);
    plan_row(FUNC_ADD, 1, 2, 6);
    plan_row(FUNC_ADD, 2, 2, 6);
    plan_row(FUNC_PROC, 0, 0, 100);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) offer_word(plan[i].w, plan[i].typed, plan[i].res);

    // fill every slot behind a long receiver hold-off, then expire them all
    wall_ms = $urandom();
    hold_len <= 400;
    for (int id = 0; id < NUM_IDS; id++) begin
      w = '{func: FUNC_ADD, timer_id: ID_W'(id), delay_ms: DELAY_W'(id % 4),
            now_ms: wall_ms};
      offer_word(w, 1'b0, none);
    end
    w = '{func: FUNC_PROC, timer_id: '0, delay_ms: '0, now_ms: wall_ms + 10};
    offer_word(w, 1'b0, none);
    item.valid <= 1'b0;
    drain_results();

    wall_ms = $urandom_range(1) ? 32'hFFFF_FE00 : $urandom();
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle  = snd_plan[ph];
      rcv_stall = rcv_plan[ph];
      for (int n = 0; n < 30; n++) begin
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0) wall_ms = $urandom();
        else wall_ms += $urandom_range(60);
        w.func     = pick < 45 ? FUNC_ADD : pick < 65 ? FUNC_DEL :
                     pick < 95 ? FUNC_PROC : FUNC_UNUSED;
        w.timer_id = ID_W'($urandom_range(NUM_IDS - 1));
        w.delay_ms = ($urandom_range(9) == 0) ? DELAY_W'($urandom()) :
                                                DELAY_W'($urandom_range(300));
        w.now_ms   = wall_ms;
        offer_word(w, 1'b0, none);
      end
    end
    item.valid <= 1'b0;
    drain_results();

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
